FILE: hdl/ctt_pkg.sv
package ctt_pkg;

   localparam int FUNC_W      = 2;
   localparam int CTX_W       = 12;
   localparam int SYMBOL_W    = 3;
   localparam int STATUS_W    = 2;
   localparam int FREQ_W      = 32;
   localparam int TOTAL_W     = 35;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int NUM_SYM_W   = 4;

   // Operation codes of a request.
   localparam logic [FUNC_W-1:0] FUNC_UPDATE  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_COMPUTE = 2'd2;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FREQ      = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_NUM_SYMBOLS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_COUNT   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DELTA_NUM   = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DELTA_DEN   = 2'd3;

   localparam logic [NUM_SYM_W-1:0]  NUM_SYMBOLS_RESET = 4'd4;
   localparam logic [CSR_DATA_W-1:0] MAX_COUNT_RESET   = 16'd0;
   localparam logic [CSR_DATA_W-1:0] DELTA_NUM_RESET   = 16'd1;
   localparam logic [CSR_DATA_W-1:0] DELTA_DEN_RESET   = 16'd1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD,
      ST_MODIFY,
      ST_HALVE,
      ST_WRITE,
      ST_RESPOND,
      ST_MUL,
      ST_ADD,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      KIND_UPDATE,
      KIND_REMOVE,
      KIND_COMPUTE,
      KIND_NOP
   } kind_type;

   typedef enum logic [1:0] {
      CNT_INC,
      CNT_DEC,
      CNT_HALF
   } cnt_op_type;

   typedef struct packed {
      logic is_full;
      logic is_zero;
      logic hit_limit;
   } cnt_flags_type;

endpackage

FILE: hdl/context_counter_table_core.sv
// Counter table of 2**INDEX_BITS rows, MAX_SYMBOLS counters each.
// After reset the table is cleared one row per cycle; no request is taken until every row is cleared.
// Update and remove of an in-use symbol pass LOAD, MODIFY, WRITE and RESPOND, with a HALVE step per
// in-use symbol when the row is halved; any other update, remove or unknown operation: LOAD, RESPOND.
// Compute: LOAD, then MUL, ADD and EMIT for each in-use symbol; the multiply and add unit is shared over symbols.
// One request at a time; the next is taken as soon as the last result is registered.
module context_counter_table_core #(
   parameter int INDEX_BITS  = 12,
   parameter int MAX_SYMBOLS = 8,
   parameter int COUNT_BITS  = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [ctt_pkg::FUNC_W-1:0]         req_func,
   input  logic [ctt_pkg::CTX_W-1:0]          req_ctx_index,
   input  logic [ctt_pkg::SYMBOL_W-1:0]       req_symbol,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [ctt_pkg::STATUS_W-1:0]       rsp_status,
   output logic [ctt_pkg::SYMBOL_W-1:0]       rsp_symbol_out,
   output logic [ctt_pkg::FREQ_W-1:0]         rsp_freq,
   output logic [ctt_pkg::TOTAL_W-1:0]        rsp_total,
   output logic                               rsp_last,
   input  logic                               csr_wen,
   input  logic [ctt_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ctt_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int SYM_W     = $clog2(MAX_SYMBOLS);
   localparam int SYM_CNT_W = $clog2(MAX_SYMBOLS + 1);
   localparam int ROW_W     = MAX_SYMBOLS * COUNT_BITS;
   localparam int EXT_W     = ctt_pkg::CTX_W + INDEX_BITS;

   ctt_pkg::state_type state_ff, state_in;
   ctt_pkg::kind_type  kind_ff, kind_in;

   logic [INDEX_BITS-1:0]                   row_addr_ff, row_addr_in;
   logic [INDEX_BITS-1:0]                   clr_addr_ff, clr_addr_in;
   logic [SYM_CNT_W-1:0]                    n_ff, n_in;
   logic [SYM_W-1:0]                        step_ff, step_in;
   logic [MAX_SYMBOLS-1:0][COUNT_BITS-1:0]  row_ff, row_in;
   logic [ctt_pkg::TOTAL_W-1:0]             total_ff, total_in;
   logic [ctt_pkg::STATUS_W-1:0]            status_ff, status_in;

   logic                                    rsp_valid_ff, rsp_valid_in;
   logic [ctt_pkg::STATUS_W-1:0]            rsp_status_ff, rsp_status_in;
   logic [ctt_pkg::SYMBOL_W-1:0]            rsp_symbol_ff, rsp_symbol_in;
   logic [ctt_pkg::FREQ_W-1:0]              rsp_freq_ff, rsp_freq_in;
   logic [ctt_pkg::TOTAL_W-1:0]             rsp_total_ff, rsp_total_in;
   logic                                    rsp_last_ff, rsp_last_in;

   logic [ctt_pkg::NUM_SYM_W-1:0]           cfg_num_symbols_ff;
   logic [ctt_pkg::CSR_DATA_W-1:0]          cfg_max_count_ff;
   logic [ctt_pkg::CSR_DATA_W-1:0]          cfg_delta_num_ff;
   logic [ctt_pkg::CSR_DATA_W-1:0]          cfg_delta_den_ff;

   logic [EXT_W-1:0]                        ctx_ext;
   logic [INDEX_BITS-1:0]                   req_row;
   logic [SYM_W+ctt_pkg::SYMBOL_W-1:0]      sym_ext;
   logic [SYM_W+ctt_pkg::SYMBOL_W-1:0]      step_ext;
   logic [7:0]                              n_eff_wide;
   logic [SYM_CNT_W-1:0]                    n_eff;
   logic                                    sym_in_use;
   logic                                    step_last;
   logic                                    out_free;
   logic                                    accept;
   logic [ctt_pkg::TOTAL_W:0]               total_sum;

   logic                                    mem_wen;
   logic [INDEX_BITS-1:0]                   mem_waddr;
   logic [ROW_W-1:0]                        mem_wdata;
   logic [ROW_W-1:0]                        mem_rdata;

   ctt_pkg::cnt_op_type                     cnt_op;
   logic [COUNT_BITS-1:0]                   cnt_result;
   ctt_pkg::cnt_flags_type                  cnt_flags;

   logic                                    mul_en;
   logic                                    add_en;
   logic [ctt_pkg::FREQ_W-1:0]              unit_freq;

   // The context index is zero-extended or cut to the row address width.
   assign ctx_ext  = {INDEX_BITS'(0), req_ctx_index};
   assign req_row  = ctx_ext[INDEX_BITS-1:0];
   assign sym_ext  = {SYM_W'(0), req_symbol};
   assign step_ext = {ctt_pkg::SYMBOL_W'(0), step_ff};

   always_comb begin
      if (cfg_num_symbols_ff == '0) begin
         n_eff_wide = 8'd1;
      end else if (8'(cfg_num_symbols_ff) > 8'(MAX_SYMBOLS)) begin
         n_eff_wide = 8'(MAX_SYMBOLS);
      end else begin
         n_eff_wide = 8'(cfg_num_symbols_ff);
      end
   end

   assign n_eff      = n_eff_wide[SYM_CNT_W-1:0];
   assign sym_in_use = 8'(req_symbol) < n_eff_wide;
   assign step_last  = (SYM_CNT_W'(step_ff) + SYM_CNT_W'(1)) == n_ff;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign req_ready  = (state_ff == ctt_pkg::ST_IDLE);
   assign accept     = req_valid && req_ready;
   assign total_sum  = {1'b0, total_ff} + (ctt_pkg::TOTAL_W + 1)'(unit_freq);

   assign mem_waddr = (state_ff == ctt_pkg::ST_CLEAR) ? clr_addr_ff : row_addr_ff;
   assign mem_wdata = (state_ff == ctt_pkg::ST_CLEAR) ? '0 : row_ff;

   ctt_row_mem #(
      .ADDR_W (INDEX_BITS),
      .DATA_W (ROW_W)
   ) u_row_mem (
      .clock   (clock),
      .wr_en   (mem_wen),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (accept),
      .rd_addr (req_row),
      .rd_data (mem_rdata)
   );

   ctt_count_unit #(
      .COUNT_BITS (COUNT_BITS)
   ) u_count_unit (
      .op        (cnt_op),
      .value     (row_ff[step_ff]),
      .max_count (cfg_max_count_ff),
      .result    (cnt_result),
      .flags     (cnt_flags)
   );

   ctt_freq_unit #(
      .COUNT_BITS (COUNT_BITS)
   ) u_freq_unit (
      .clock     (clock),
      .mul_en    (mul_en),
      .add_en    (add_en),
      .count     (row_ff[step_ff]),
      .delta_num (cfg_delta_num_ff),
      .delta_den (cfg_delta_den_ff),
      .freq      (unit_freq)
   );

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      row_addr_in   = row_addr_ff;
      clr_addr_in   = clr_addr_ff;
      n_in          = n_ff;
      step_in       = step_ff;
      row_in        = row_ff;
      total_in      = total_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_symbol_in = rsp_symbol_ff;
      rsp_freq_in   = rsp_freq_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_last_in   = rsp_last_ff;
      mem_wen       = 1'b0;
      cnt_op        = ctt_pkg::CNT_INC;
      mul_en        = 1'b0;
      add_en        = 1'b0;

      unique case (state_ff)
         ctt_pkg::ST_CLEAR: begin
            mem_wen     = 1'b1;
            clr_addr_in = clr_addr_ff + INDEX_BITS'(1);
            if (clr_addr_ff == {INDEX_BITS{1'b1}}) begin
               state_in = ctt_pkg::ST_IDLE;
            end
         end
         ctt_pkg::ST_IDLE: begin
            if (req_valid) begin
               row_addr_in = req_row;
               n_in        = n_eff;
               step_in     = sym_ext[SYM_W-1:0];
               state_in    = ctt_pkg::ST_LOAD;
               priority if (req_func == ctt_pkg::FUNC_COMPUTE) begin
                  kind_in = ctt_pkg::KIND_COMPUTE;
               end else if (req_func == ctt_pkg::FUNC_UPDATE && sym_in_use) begin
                  kind_in = ctt_pkg::KIND_UPDATE;
               end else if (req_func == ctt_pkg::FUNC_REMOVE && sym_in_use) begin
                  kind_in = ctt_pkg::KIND_REMOVE;
               end else begin
                  kind_in = ctt_pkg::KIND_NOP;
               end
            end
         end
         ctt_pkg::ST_LOAD: begin
            row_in = mem_rdata;
            unique case (kind_ff)
               ctt_pkg::KIND_COMPUTE: begin
                  step_in  = '0;
                  total_in = '0;
                  state_in = ctt_pkg::ST_MUL;
               end
               ctt_pkg::KIND_NOP: begin
                  status_in = ctt_pkg::STATUS_DONE;
                  state_in  = ctt_pkg::ST_RESPOND;
               end
               default: begin
                  state_in = ctt_pkg::ST_MODIFY;
               end
            endcase
         end
         ctt_pkg::ST_MODIFY: begin
            status_in = ctt_pkg::STATUS_DONE;
            state_in  = ctt_pkg::ST_WRITE;
            if (kind_ff == ctt_pkg::KIND_REMOVE) begin
               cnt_op = ctt_pkg::CNT_DEC;
               if (cnt_flags.is_zero) begin
                  status_in = ctt_pkg::STATUS_UNDERFLOW;
               end else begin
                  row_in[step_ff] = cnt_result;
               end
            end else if (!cnt_flags.is_full) begin
               row_in[step_ff] = cnt_result;
               // Reaching the limit halves every in-use counter of the row.
               if (cnt_flags.hit_limit) begin
                  step_in  = '0;
                  state_in = ctt_pkg::ST_HALVE;
               end
            end
         end
         ctt_pkg::ST_HALVE: begin
            cnt_op          = ctt_pkg::CNT_HALF;
            row_in[step_ff] = cnt_result;
            if (step_last) begin
               state_in = ctt_pkg::ST_WRITE;
            end else begin
               step_in = step_ff + SYM_W'(1);
            end
         end
         ctt_pkg::ST_WRITE: begin
            mem_wen  = 1'b1;
            state_in = ctt_pkg::ST_RESPOND;
         end
         ctt_pkg::ST_RESPOND: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_symbol_in = '0;
               rsp_freq_in   = '0;
               rsp_total_in  = '0;
               rsp_last_in   = 1'b1;
               state_in      = ctt_pkg::ST_IDLE;
            end
         end
         ctt_pkg::ST_MUL: begin
            mul_en   = 1'b1;
            state_in = ctt_pkg::ST_ADD;
         end
         ctt_pkg::ST_ADD: begin
            add_en   = 1'b1;
            state_in = ctt_pkg::ST_EMIT;
         end
         ctt_pkg::ST_EMIT: begin
            if (out_free) begin
               if (total_sum[ctt_pkg::TOTAL_W]) begin
                  total_in = '1;
               end else begin
                  total_in = total_sum[ctt_pkg::TOTAL_W-1:0];
               end
               rsp_valid_in  = 1'b1;
               rsp_status_in = ctt_pkg::STATUS_FREQ;
               rsp_symbol_in = step_ext[ctt_pkg::SYMBOL_W-1:0];
               rsp_freq_in   = unit_freq;
               rsp_total_in  = total_in;
               rsp_last_in   = step_last;
               if (step_last) begin
                  state_in = ctt_pkg::ST_IDLE;
               end else begin
                  step_in  = step_ff + SYM_W'(1);
                  state_in = ctt_pkg::ST_MUL;
               end
            end
         end
         default: begin
            state_in = ctt_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ctt_pkg::ST_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      row_addr_ff   <= row_addr_in;
      n_ff          <= n_in;
      step_ff       <= step_in;
      row_ff        <= row_in;
      total_ff      <= total_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_symbol_ff <= rsp_symbol_in;
      rsp_freq_ff   <= rsp_freq_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_num_symbols_ff <= ctt_pkg::NUM_SYMBOLS_RESET;
         cfg_max_count_ff   <= ctt_pkg::MAX_COUNT_RESET;
         cfg_delta_num_ff   <= ctt_pkg::DELTA_NUM_RESET;
         cfg_delta_den_ff   <= ctt_pkg::DELTA_DEN_RESET;
      end else if (csr_wen) begin
         unique case (csr_index)
            ctt_pkg::CSR_NUM_SYMBOLS: cfg_num_symbols_ff <= csr_wdata[ctt_pkg::NUM_SYM_W-1:0];
            ctt_pkg::CSR_MAX_COUNT:   cfg_max_count_ff   <= csr_wdata;
            ctt_pkg::CSR_DELTA_NUM:   cfg_delta_num_ff   <= csr_wdata;
            ctt_pkg::CSR_DELTA_DEN:   cfg_delta_den_ff   <= csr_wdata;
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_symbol_out = rsp_symbol_ff;
   assign rsp_freq       = rsp_freq_ff;
   assign rsp_total      = rsp_total_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

FILE: hdl/ctt_row_mem.sv
module ctt_row_mem #(
   parameter int ADDR_W = 12,
   parameter int DATA_W = 128
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   localparam int DEPTH = 2 ** ADDR_W;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/ctt_count_unit.sv
module ctt_count_unit #(
   parameter int COUNT_BITS = 16
) (
   input  ctt_pkg::cnt_op_type                 op,
   input  logic [COUNT_BITS-1:0]               value,
   input  logic [ctt_pkg::CSR_DATA_W-1:0]      max_count,
   output logic [COUNT_BITS-1:0]               result,
   output ctt_pkg::cnt_flags_type              flags
);

   localparam int CMP_W = (COUNT_BITS > ctt_pkg::CSR_DATA_W) ? COUNT_BITS : ctt_pkg::CSR_DATA_W;

   logic [CMP_W-1:0] inc_wide;

   assign inc_wide = CMP_W'(value) + CMP_W'(1);

   // The limit only counts when halving is enabled, that is a nonzero maximum.
   assign flags.is_full   = (value == {COUNT_BITS{1'b1}});
   assign flags.is_zero   = (value == '0);
   assign flags.hit_limit = (max_count != '0) && (inc_wide == CMP_W'(max_count));

   always_comb begin
      unique case (op)
         ctt_pkg::CNT_INC:  result = value + COUNT_BITS'(1);
         ctt_pkg::CNT_DEC:  result = value - COUNT_BITS'(1);
         ctt_pkg::CNT_HALF: result = value >> 1;
         default:           result = value;
      endcase
   end

endmodule

FILE: hdl/ctt_freq_unit.sv
module ctt_freq_unit #(
   parameter int COUNT_BITS = 16
) (
   input  logic                            clock,
   input  logic                            mul_en,
   input  logic                            add_en,
   input  logic [COUNT_BITS-1:0]           count,
   input  logic [ctt_pkg::CSR_DATA_W-1:0]  delta_num,
   input  logic [ctt_pkg::CSR_DATA_W-1:0]  delta_den,
   output logic [ctt_pkg::FREQ_W-1:0]      freq
);

   localparam int PROD_W = ctt_pkg::CSR_DATA_W + COUNT_BITS;
   localparam int SUM_W  = (PROD_W + 1 > ctt_pkg::FREQ_W + 1) ? PROD_W + 1 : ctt_pkg::FREQ_W + 1;

   logic [PROD_W-1:0]          prod_ff;
   logic [SUM_W-1:0]           sum;
   logic [ctt_pkg::FREQ_W-1:0] freq_ff;

   assign sum = SUM_W'(delta_num) + SUM_W'(prod_ff);

   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= PROD_W'(delta_den) * PROD_W'(count);
      end
   end

   // The frequency saturates at the largest value of its field.
   always_ff @(posedge clock) begin
      if (add_en) begin
         if (|sum[SUM_W-1:ctt_pkg::FREQ_W]) begin
            freq_ff <= '1;
         end else begin
            freq_ff <= sum[ctt_pkg::FREQ_W-1:0];
         end
      end
   end

   assign freq = freq_ff;

endmodule

FILE: hdl/ctt_checker.sv
module ctt_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [ctt_pkg::STATUS_W-1:0]  rsp_status,
   input logic [ctt_pkg::SYMBOL_W-1:0]  rsp_symbol_out,
   input logic [ctt_pkg::FREQ_W-1:0]    rsp_freq,
   input logic [ctt_pkg::TOTAL_W-1:0]   rsp_total,
   input logic                          rsp_last
);

   // A result that is not taken holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_freq) && $stable(rsp_total)
                                  && $stable(rsp_status) && $stable(rsp_last))
      else $error("held result changed");

   // A request is worked on one at a time; the block is busy right after taking it.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // Update and remove answer with a single result.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ctt_pkg::STATUS_FREQ |-> rsp_last)
      else $error("status result is not last");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ctt_pkg::STATUS_FREQ
      |-> rsp_symbol_out == '0 && rsp_freq == '0 && rsp_total == '0)
      else $error("status result carries frequency data");

   // The running total includes the current frequency.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ctt_pkg::STATUS_FREQ
      |-> rsp_total >= ctt_pkg::TOTAL_W'(rsp_freq))
      else $error("total below frequency");

endmodule

bind context_counter_table_core ctt_checker u_ctt_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_status     (rsp_status),
   .rsp_symbol_out (rsp_symbol_out),
   .rsp_freq       (rsp_freq),
   .rsp_total      (rsp_total),
   .rsp_last       (rsp_last)
);
